// ===== src/complex_arith_unit_top_defines.svh =====
// Assertion macros for the complex arithmetic unit.
// Included by cau_back, which checks its own logic with them; no other dependencies.
`ifndef COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cau assertion failed");
`define CAU_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("cau forbidden condition");
`else
`define CAU_ASSERT(lbl, clk, rstn, prop)
`define CAU_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== src/cau_pkg.sv =====
// Shared types, opcodes and helper functions of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQ_STEPS      = 32;

  localparam logic [34:0] QCAP = 35'd8589934592;

  localparam logic [2:0] FN_ADD  = 3'd0;
  localparam logic [2:0] FN_SUB  = 3'd1;
  localparam logic [2:0] FN_MUL  = 3'd2;
  localparam logic [2:0] FN_DIV  = 3'd3;
  localparam logic [2:0] FN_ABS  = 3'd4;
  localparam logic [2:0] FN_SQRT = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] rr;
    logic [31:0] ri;
    logic [1:0]  st;
    logic        re_neg;
    logic        im_neg;
    logic        dz;
    logic        a_neg;
    logic        b_neg;
    logic        xz;
    logic [32:0] w;
  } ctx_t;

  typedef struct packed {
    logic [63:0] n_re;
    logic [63:0] n_im;
    logic [63:0] den;
    logic [31:0] ma;
    logic [31:0] mb;
  } arg_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    logic [63:0] n0;
    logic [63:0] n1;
    logic [63:0] r0;
    logic [63:0] r1;
    logic [63:0] d;
    logic [34:0] q0;
    logic [34:0] q1;
  } dv_t;

  function automatic logic [64:0] sm_add(input logic n1, input logic [63:0] m1,
                                         input logic n2, input logic [63:0] m2);
    logic        n;
    logic [63:0] m;
    if (n1 == n2) begin
      n = n1;
      m = m1 + m2;
    end else if (m1 >= m2) begin
      n = n1;
      m = m1 - m2;
    end else begin
      n = n2;
      m = m2 - m1;
    end
    return {n, m};
  endfunction

  function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] m);
    logic [31:0] v;
    logic        ovf;
    ovf = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        ovf = 1'b1;
        v   = 32'h8000_0000;
      end else begin
        v = 32'd0 - m[31:0];
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        v   = 32'h7FFF_FFFF;
      end else begin
        v = m[31:0];
      end
    end
    return {ovf, v};
  endfunction

endpackage

// ===== src/cau_sqrt_cell.sv =====
// One digit step of the pipelined integer square root.
// Depends on cau_pkg.
module cau_sqrt_cell
  import cau_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  ctx_t ctx_i,
  input  arg_t arg_i,
  input  sq_t  sq_i,
  output logic valid_o,
  output ctx_t ctx_o,
  output arg_t arg_o,
  output sq_t  sq_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic        valid_r;
  ctx_t        ctx_r;
  arg_t        arg_r;
  sq_t         sq_r;
  sq_t         sq_nxt;
  logic [63:0] t;

  always_comb begin
    t = sq_i.res + BIT;
    if (sq_i.x >= t) begin
      sq_nxt.x   = sq_i.x - t;
      sq_nxt.res = (sq_i.res >> 1) + BIT;
    end else begin
      sq_nxt.x   = sq_i.x;
      sq_nxt.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_i;
    arg_r <= arg_i;
    sq_r  <= sq_nxt;
  end

  assign valid_o = valid_r;
  assign ctx_o   = ctx_r;
  assign arg_o   = arg_r;
  assign sq_o    = sq_r;

endmodule

// ===== src/cau_div_cell.sv =====
// One restoring step of the two-lane pipelined divider.
// Depends on cau_pkg.
module cau_div_cell
  import cau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  ctx_t ctx_i,
  input  dv_t  dv_i,
  output logic valid_o,
  output ctx_t ctx_o,
  output dv_t  dv_o
);

  function automatic logic [162:0] div_step(input logic [63:0] n, input logic [63:0] r,
                                            input logic [34:0] q, input logic [63:0] d);
    logic [63:0] rs;
    logic [34:0] qs;
    rs = {r[62:0], n[63]};
    qs = {q[33:0], 1'b0};
    if (rs >= d) begin
      rs    = rs - d;
      qs[0] = 1'b1;
    end
    if (qs > QCAP) begin
      qs = QCAP;
    end
    return {n << 1, rs, qs};
  endfunction

  logic valid_r;
  ctx_t ctx_r;
  dv_t  dv_r;
  dv_t  dv_nxt;

  always_comb begin
    dv_nxt.d = dv_i.d;
    {dv_nxt.n0, dv_nxt.r0, dv_nxt.q0} = div_step(dv_i.n0, dv_i.r0, dv_i.q0, dv_i.d);
    {dv_nxt.n1, dv_nxt.r1, dv_nxt.q1} = div_step(dv_i.n1, dv_i.r1, dv_i.q1, dv_i.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_i;
    dv_r  <= dv_nxt;
  end

  assign valid_o = valid_r;
  assign ctx_o   = ctx_r;
  assign dv_o    = dv_r;

endmodule

// ===== src/cau_front.sv =====
// Operand capture, magnitudes, products and signed sums; add, sub and mul finish here.
// Depends on cau_pkg.
module cau_front
  import cau_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  logic [2:0]  func_i,
  input  logic [31:0] x_re_i,
  input  logic [31:0] x_im_i,
  input  logic [31:0] y_re_i,
  input  logic [31:0] y_im_i,
  output logic        valid_o,
  output ctx_t        ctx_o,
  output arg_t        arg_o,
  output sq_t         sq_o
);

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  // stage A
  logic        a_vld_r;
  logic [2:0]  a_func_r;
  logic [31:0] a_a_r, a_b_r, a_c_r, a_d_r;

  // stage B
  logic        b_vld_r;
  logic [2:0]  b_func_r;
  logic [31:0] b_ma_r, b_mb_r, b_mc_r, b_md_r;
  logic        b_an_r, b_bn_r, b_cn_r, b_dn_r, b_xz_r;
  logic [31:0] b_rr_r, b_ri_r;
  logic [1:0]  b_st_r;
  logic [31:0] b_rr_nxt, b_ri_nxt;
  logic [1:0]  b_st_nxt;
  logic [32:0] s_re, s_im, g_re, g_im;
  logic [32:0] t_re, t_im;

  // stage C
  logic        c_vld_r;
  logic [2:0]  c_func_r;
  logic [31:0] c_ma_r, c_mb_r;
  logic        c_an_r, c_bn_r, c_cn_r, c_dn_r, c_xz_r;
  logic [31:0] c_rr_r, c_ri_r;
  logic [1:0]  c_st_r;
  logic [63:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r, p_cc_r, p_dd_r;
  logic [31:0] op_ac, op_bd;

  // stage D
  logic        d_vld_r;
  logic [2:0]  d_func_r;
  logic [31:0] d_ma_r, d_mb_r;
  logic        d_an_r, d_bn_r, d_xz_r;
  logic [31:0] d_rr_r, d_ri_r;
  logic [1:0]  d_st_r;
  logic [64:0] d_mre_r, d_mim_r, d_dre_r, d_dim_r;
  logic [63:0] d_den_r, d_s_r;

  logic [32:0] sat_re, sat_im;
  logic [63:0] rnd_re, rnd_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= valid_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_func_r <= func_i;
    a_a_r    <= x_re_i;
    a_b_r    <= x_im_i;
    a_c_r    <= y_re_i;
    a_d_r    <= y_im_i;
  end

  always_comb begin
    if (a_func_r == FN_SUB) begin
      s_re = {a_a_r[31], a_a_r} - {a_c_r[31], a_c_r};
      s_im = {a_b_r[31], a_b_r} - {a_d_r[31], a_d_r};
    end else begin
      s_re = {a_a_r[31], a_a_r} + {a_c_r[31], a_c_r};
      s_im = {a_b_r[31], a_b_r} + {a_d_r[31], a_d_r};
    end
    g_re = s_re[32] ? 33'd0 - s_re : s_re;
    g_im = s_im[32] ? 33'd0 - s_im : s_im;
    t_re = sat_sm(s_re[32], 64'(g_re));
    t_im = sat_sm(s_im[32], 64'(g_im));
    if (a_func_r == FN_ADD || a_func_r == FN_SUB) begin
      b_rr_nxt = t_re[31:0];
      b_ri_nxt = t_im[31:0];
      b_st_nxt = (t_re[32] || t_im[32]) ? ST_SAT : ST_OK;
    end else begin
      b_rr_nxt = 32'd0;
      b_ri_nxt = 32'd0;
      b_st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    b_func_r <= a_func_r;
    b_ma_r   <= a_a_r[31] ? 32'd0 - a_a_r : a_a_r;
    b_mb_r   <= a_b_r[31] ? 32'd0 - a_b_r : a_b_r;
    b_mc_r   <= a_c_r[31] ? 32'd0 - a_c_r : a_c_r;
    b_md_r   <= a_d_r[31] ? 32'd0 - a_d_r : a_d_r;
    b_an_r   <= a_a_r[31];
    b_bn_r   <= a_b_r[31];
    b_cn_r   <= a_c_r[31];
    b_dn_r   <= a_d_r[31];
    b_xz_r   <= (a_a_r == 32'd0) && (a_b_r == 32'd0);
    b_rr_r   <= b_rr_nxt;
    b_ri_r   <= b_ri_nxt;
    b_st_r   <= b_st_nxt;
  end

  // magnitude ops reuse the ac and bd multipliers as squares
  assign op_ac = (b_func_r == FN_ABS || b_func_r == FN_SQRT) ? b_ma_r : b_mc_r;
  assign op_bd = (b_func_r == FN_ABS || b_func_r == FN_SQRT) ? b_mb_r : b_md_r;

  always_ff @(posedge clk) begin
    c_func_r <= b_func_r;
    c_ma_r   <= b_ma_r;
    c_mb_r   <= b_mb_r;
    c_an_r   <= b_an_r;
    c_bn_r   <= b_bn_r;
    c_cn_r   <= b_cn_r;
    c_dn_r   <= b_dn_r;
    c_xz_r   <= b_xz_r;
    c_rr_r   <= b_rr_r;
    c_ri_r   <= b_ri_r;
    c_st_r   <= b_st_r;
    p_ac_r   <= 64'(b_ma_r) * 64'(op_ac);
    p_bd_r   <= 64'(b_mb_r) * 64'(op_bd);
    p_ad_r   <= 64'(b_ma_r) * 64'(b_md_r);
    p_bc_r   <= 64'(b_mb_r) * 64'(b_mc_r);
    p_cc_r   <= 64'(b_mc_r) * 64'(b_mc_r);
    p_dd_r   <= 64'(b_md_r) * 64'(b_md_r);
  end

  always_ff @(posedge clk) begin
    d_func_r <= c_func_r;
    d_ma_r   <= c_ma_r;
    d_mb_r   <= c_mb_r;
    d_an_r   <= c_an_r;
    d_bn_r   <= c_bn_r;
    d_xz_r   <= c_xz_r;
    d_rr_r   <= c_rr_r;
    d_ri_r   <= c_ri_r;
    d_st_r   <= c_st_r;
    d_mre_r  <= sm_add(c_an_r ^ c_cn_r, p_ac_r, !(c_bn_r ^ c_dn_r), p_bd_r);
    d_mim_r  <= sm_add(c_an_r ^ c_dn_r, p_ad_r, c_bn_r ^ c_cn_r, p_bc_r);
    d_dre_r  <= sm_add(c_an_r ^ c_cn_r, p_ac_r, c_bn_r ^ c_dn_r, p_bd_r);
    d_dim_r  <= sm_add(c_bn_r ^ c_cn_r, p_bc_r, !(c_an_r ^ c_dn_r), p_ad_r);
    d_den_r  <= p_cc_r + p_dd_r;
    d_s_r    <= p_ac_r + p_bd_r;
  end

  assign rnd_re = (d_mre_r[63:0] + HALF) >> FRAC_BITS;
  assign rnd_im = (d_mim_r[63:0] + HALF) >> FRAC_BITS;
  assign sat_re = sat_sm(d_mre_r[64], rnd_re);
  assign sat_im = sat_sm(d_mim_r[64], rnd_im);

  always_comb begin
    ctx_o.func   = d_func_r;
    ctx_o.rr     = d_rr_r;
    ctx_o.ri     = d_ri_r;
    ctx_o.st     = d_st_r;
    ctx_o.re_neg = d_dre_r[64];
    ctx_o.im_neg = d_dim_r[64];
    ctx_o.dz     = (d_den_r == 64'd0);
    ctx_o.a_neg  = d_an_r;
    ctx_o.b_neg  = d_bn_r;
    ctx_o.xz     = d_xz_r;
    ctx_o.w      = 33'd0;
    if (d_func_r == FN_MUL) begin
      ctx_o.rr = sat_re[31:0];
      ctx_o.ri = sat_im[31:0];
      ctx_o.st = (sat_re[32] || sat_im[32]) ? ST_SAT : ST_OK;
    end else if (d_func_r == FN_DIV && d_den_r == 64'd0) begin
      ctx_o.st = ST_DZ;
    end
  end

  assign arg_o.n_re = d_dre_r[63:0];
  assign arg_o.n_im = d_dim_r[63:0];
  assign arg_o.den  = d_den_r;
  assign arg_o.ma   = d_ma_r;
  assign arg_o.mb   = d_mb_r;
  assign sq_o.x     = d_s_r;
  assign sq_o.res   = 64'd0;
  assign valid_o    = d_vld_r;

endmodule

// ===== src/cau_back.sv =====
// Final quotient rounding, saturation and result selection; drives the result register.
// Depends on cau_pkg and complex_arith_unit_top_defines.svh.
`include "complex_arith_unit_top_defines.svh"
module cau_back
  import cau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  ctx_t        ctx_i,
  input  dv_t         dv_i,
  output logic        out_valid,
  output logic [31:0] out_r_re,
  output logic [31:0] out_r_im,
  output logic [1:0]  out_status
);

  logic        out_valid_r;
  logic [31:0] out_r_re_r, out_r_im_r;
  logic [1:0]  out_status_r;
  logic [31:0] rr_nxt, ri_nxt;
  logic [1:0]  st_nxt;
  logic [34:0] q0f, q1f;
  logic [32:0] s_re, s_im;

  assign q0f = dv_i.q0 + 35'(dv_i.r0 >= dv_i.d - dv_i.r0);
  assign q1f = dv_i.q1 + 35'(dv_i.r1 >= dv_i.d - dv_i.r1);

  always_comb begin
    s_re   = 33'd0;
    s_im   = 33'd0;
    rr_nxt = ctx_i.rr;
    ri_nxt = ctx_i.ri;
    st_nxt = ctx_i.st;
    case (ctx_i.func)
      FN_DIV: begin
        if (!ctx_i.dz) begin
          s_re   = sat_sm(ctx_i.re_neg, 64'(q0f));
          s_im   = sat_sm(ctx_i.im_neg, 64'(q1f));
          rr_nxt = s_re[31:0];
          ri_nxt = s_im[31:0];
          st_nxt = (s_re[32] || s_im[32]) ? ST_SAT : ST_OK;
        end
      end
      FN_SQRT: begin
        if (!ctx_i.xz) begin
          if (!ctx_i.a_neg) begin
            s_re = sat_sm(1'b0, 64'(ctx_i.w));
            s_im = sat_sm(ctx_i.b_neg, 64'(q0f));
          end else begin
            s_re = sat_sm(1'b0, 64'(q0f));
            s_im = sat_sm(ctx_i.b_neg, 64'(ctx_i.w));
          end
          rr_nxt = s_re[31:0];
          ri_nxt = s_im[31:0];
          st_nxt = (s_re[32] || s_im[32]) ? ST_SAT : ST_OK;
        end
      end
      default: begin
        rr_nxt = ctx_i.rr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    out_r_re_r   <= rr_nxt;
    out_r_im_r   <= ri_nxt;
    out_status_r <= st_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_r_re   = out_r_re_r;
  assign out_r_im   = out_r_im_r;
  assign out_status = out_status_r;

  `CAU_ASSERT(a_sqrt_re_nonneg, clk, rst_n, valid_i && ctx_i.func == FN_SQRT |=> !out_r_re_r[31])
  `CAU_ASSERT(a_abs_shape, clk, rst_n, valid_i && ctx_i.func == FN_ABS |=> !out_r_re_r[31] && out_r_im_r == 32'd0)
  `CAU_ASSERT(a_dz_zero, clk, rst_n, out_valid_r && out_status_r == ST_DZ |-> out_r_re_r == 32'd0 && out_r_im_r == 32'd0)
  `CAU_ASSERT_NEVER(a_status_code, clk, rst_n, out_valid_r && out_status_r != ST_OK && out_status_r != ST_SAT && out_status_r != ST_DZ)

endmodule

// ===== src/complex_arith_unit_top.sv =====
// Complex-number ALU on signed Q16.16 operands: add, sub, mul, div, abs, sqrt.
// A transaction is taken on every cycle that start is high; busy is always low.
// Each result appears on the out_ ports for one cycle with out_valid high, in
// start order; the receiver cannot stall it. The pipeline is a chain of 4
// operand/product stages, two 32-cell square-root chains, a (64 + FRAC_BITS)-cell
// restoring divider and the output register. Depends on cau_pkg and the cau_*
// modules.
module complex_arith_unit_top
  import cau_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_x_re,
  input  logic [31:0] in_x_im,
  input  logic [31:0] in_y_re,
  input  logic [31:0] in_y_im,
  output logic        out_valid,
  output logic [31:0] out_r_re,
  output logic [31:0] out_r_im,
  output logic [1:0]  out_status
);

  localparam int unsigned DIV_STEPS = 64 + FRAC_BITS;

  logic s1_vld [0:SQ_STEPS];
  ctx_t s1_ctx [0:SQ_STEPS];
  arg_t s1_arg [0:SQ_STEPS];
  sq_t  s1_sq  [0:SQ_STEPS];

  logic s2_vld [0:SQ_STEPS];
  ctx_t s2_ctx [0:SQ_STEPS];
  arg_t s2_arg [0:SQ_STEPS];
  sq_t  s2_sq  [0:SQ_STEPS];

  logic dv_vld [0:DIV_STEPS];
  ctx_t dv_ctx [0:DIV_STEPS];
  dv_t  dv_dat [0:DIV_STEPS];

  logic [32:0] mg, w;
  logic [32:0] mg_sat;

  assign busy = 1'b0;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .func_i  (in_func),
    .x_re_i  (in_x_re),
    .x_im_i  (in_x_im),
    .y_re_i  (in_y_re),
    .y_im_i  (in_y_im),
    .valid_o (s1_vld[0]),
    .ctx_o   (s1_ctx[0]),
    .arg_o   (s1_arg[0]),
    .sq_o    (s1_sq[0])
  );

  for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sq1
    cau_sqrt_cell #(.STEP(gi)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (s1_vld[gi]),
      .ctx_i   (s1_ctx[gi]),
      .arg_i   (s1_arg[gi]),
      .sq_i    (s1_sq[gi]),
      .valid_o (s1_vld[gi+1]),
      .ctx_o   (s1_ctx[gi+1]),
      .arg_o   (s1_arg[gi+1]),
      .sq_o    (s1_sq[gi+1])
    );
  end

  // round the magnitude, finish abs, seed the half-sum root
  assign mg     = s1_sq[SQ_STEPS].res[32:0] +
                  33'(s1_sq[SQ_STEPS].x > s1_sq[SQ_STEPS].res);
  assign mg_sat = sat_sm(1'b0, 64'(mg));

  always_comb begin
    s2_vld[0]    = s1_vld[SQ_STEPS];
    s2_ctx[0]    = s1_ctx[SQ_STEPS];
    s2_arg[0]    = s1_arg[SQ_STEPS];
    s2_sq[0].x   = (64'(s1_arg[SQ_STEPS].ma) + 64'(mg)) << (FRAC_BITS - 1);
    s2_sq[0].res = 64'd0;
    if (s1_ctx[SQ_STEPS].func == FN_ABS) begin
      s2_ctx[0].rr = mg_sat[31:0];
      s2_ctx[0].st = mg_sat[32] ? ST_SAT : ST_OK;
    end
  end

  for (genvar gj = 0; gj < SQ_STEPS; gj++) begin : g_sq2
    cau_sqrt_cell #(.STEP(gj)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (s2_vld[gj]),
      .ctx_i   (s2_ctx[gj]),
      .arg_i   (s2_arg[gj]),
      .sq_i    (s2_sq[gj]),
      .valid_o (s2_vld[gj+1]),
      .ctx_o   (s2_ctx[gj+1]),
      .arg_o   (s2_arg[gj+1]),
      .sq_o    (s2_sq[gj+1])
    );
  end

  assign w = s2_sq[SQ_STEPS].res[32:0] + 33'(s2_sq[SQ_STEPS].x > s2_sq[SQ_STEPS].res);

  always_comb begin
    dv_vld[0]      = s2_vld[SQ_STEPS];
    dv_ctx[0]      = s2_ctx[SQ_STEPS];
    dv_ctx[0].w    = w;
    dv_dat[0].r0   = 64'd0;
    dv_dat[0].r1   = 64'd0;
    dv_dat[0].q0   = 35'd0;
    dv_dat[0].q1   = 35'd0;
    dv_dat[0].n1   = s2_arg[SQ_STEPS].n_im;
    if (s2_ctx[SQ_STEPS].func == FN_SQRT) begin
      dv_dat[0].n0 = 64'(s2_arg[SQ_STEPS].mb);
      dv_dat[0].d  = 64'({w, 1'b0});
    end else begin
      dv_dat[0].n0 = s2_arg[SQ_STEPS].n_re;
      dv_dat[0].d  = s2_arg[SQ_STEPS].den;
    end
  end

  for (genvar gk = 0; gk < DIV_STEPS; gk++) begin : g_div
    cau_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv_vld[gk]),
      .ctx_i   (dv_ctx[gk]),
      .dv_i    (dv_dat[gk]),
      .valid_o (dv_vld[gk+1]),
      .ctx_o   (dv_ctx[gk+1]),
      .dv_o    (dv_dat[gk+1])
    );
  end

  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (dv_vld[DIV_STEPS]),
    .ctx_i      (dv_ctx[DIV_STEPS]),
    .dv_i       (dv_dat[DIV_STEPS]),
    .out_valid  (out_valid),
    .out_r_re   (out_r_re),
    .out_r_im   (out_r_im),
    .out_status (out_status)
  );

endmodule

// ===== tb/complex_arith_unit_top_tb.sv =====
// Self-checking testbench for complex_arith_unit_top: directed and random complex operations.
// A scoreboard class predicts each result from the operands; depends on cau_pkg and the RTL.
module complex_arith_unit_top_tb;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1350;
  localparam logic [2:0] FN_BAD6 = 3'd6;
  localparam logic [2:0] FN_BAD7 = 3'd7;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cresult_t;

  typedef longint unsigned u64_t;

  class alu_scoreboard;
    cresult_t pending[$];
    int       errors;
    bit       ovf;

    function u64_t mag(longint v);
      return v < 0 ? u64_t'(-v) : u64_t'(v);
    endfunction

    function u64_t sm_sum(bit n1, u64_t m1, bit n2, u64_t m2, output bit n);
      if (n1 == n2) begin
        n = n1;
        return m1 + m2;
      end else if (m1 >= m2) begin
        n = n1;
        return m1 - m2;
      end
      n = n2;
      return m2 - m1;
    endfunction

    function logic [31:0] clamp(bit neg, u64_t m);
      if (neg) begin
        if (m > 64'h8000_0000) begin
          m = 64'h8000_0000;
          ovf = 1;
        end
        return 32'(u64_t'(0) - m);
      end
      if (m > 64'h7FFF_FFFF) begin
        m = 64'h7FFF_FFFF;
        ovf = 1;
      end
      return m[31:0];
    endfunction

    function u64_t round_q(u64_t m);
      return (m + (u64_t'(1) << (FRAC - 1))) >> FRAC;
    endfunction

    function u64_t fix_quotient(u64_t n, u64_t d);
      u64_t r, q, b;
      r = 0;
      q = 0;
      for (int i = 63 + FRAC; i >= 0; i--) begin
        b = (i >= FRAC) ? ((n >> (i - FRAC)) & 1) : 0;
        r = (r << 1) | b;
        q = q << 1;
        if (r >= d) begin
          r -= d;
          q |= 1;
        end
        if (q > (u64_t'(1) << 33)) q = u64_t'(1) << 33;
      end
      if (r >= d - r) q++;
      return q;
    endfunction

    function u64_t root_rn(u64_t s);
      u64_t res, b, x;
      res = 0;
      b = u64_t'(1) << 62;
      x = s;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      if (s - res * res > res) res++;
      return res;
    endfunction

    function cresult_t compute(logic [2:0] f, logic [31:0] xr, logic [31:0] xi,
                               logic [31:0] yr, logic [31:0] yi);
      cresult_t r;
      longint a, b, c, d;
      u64_t ma, mb, mc, md, m, den, mg, w, q;
      bit n;
      a = longint'($signed(xr));
      b = longint'($signed(xi));
      c = longint'($signed(yr));
      d = longint'($signed(yi));
      ma = mag(a);
      mb = mag(b);
      mc = mag(c);
      md = mag(d);
      r.re = 0;
      r.im = 0;
      r.st = ST_OK;
      ovf = 0;
      case (f)
        FN_ADD: begin
          r.re = clamp(a + c < 0, mag(a + c));
          r.im = clamp(b + d < 0, mag(b + d));
        end
        FN_SUB: begin
          r.re = clamp(a - c < 0, mag(a - c));
          r.im = clamp(b - d < 0, mag(b - d));
        end
        FN_MUL: begin
          m = sm_sum((a < 0) != (c < 0), ma * mc, (b < 0) == (d < 0), mb * md, n);
          r.re = clamp(n, round_q(m));
          m = sm_sum((a < 0) != (d < 0), ma * md, (b < 0) != (c < 0), mb * mc, n);
          r.im = clamp(n, round_q(m));
        end
        FN_DIV: begin
          den = mc * mc + md * md;
          if (den == 0) begin
            r.st = ST_DZ;
          end else begin
            m = sm_sum((a < 0) != (c < 0), ma * mc, (b < 0) != (d < 0), mb * md, n);
            r.re = clamp(n, fix_quotient(m, den));
            m = sm_sum((b < 0) != (c < 0), mb * mc, (a < 0) == (d < 0), ma * md, n);
            r.im = clamp(n, fix_quotient(m, den));
          end
        end
        FN_ABS: r.re = clamp(0, root_rn(ma * ma + mb * mb));
        FN_SQRT: begin
          if (a != 0 || b != 0) begin
            mg = root_rn(ma * ma + mb * mb);
            w = root_rn((ma + mg) << (FRAC - 1));
            q = ((mb << FRAC) + w) / (2 * w);
            if (a >= 0) begin
              r.re = clamp(0, w);
              r.im = clamp(b < 0, q);
            end else begin
              r.re = clamp(0, q);
              r.im = clamp(b < 0, w);
            end
          end
        end
        default: ;
      endcase
      if (ovf && r.st == ST_OK) r.st = ST_SAT;
      return r;
    endfunction

    function void note_input(logic [2:0] f, logic [31:0] xr, logic [31:0] xi,
                             logic [31:0] yr, logic [31:0] yi);
      pending.push_back(compute(f, xr, xi, yr, yi));
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    function void check_result(logic [31:0] re, logic [31:0] im, logic [1:0] st);
      cresult_t e;
      if (pending.size() == 0) begin
        report("unexpected result", re, 0);
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) report("r_re", re, e.re);
      if (im !== e.im) report("r_im", im, e.im);
      if (st !== e.st) report("status", 32'(st), 32'(e.st));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_func = 0;
  logic [31:0] in_x_re = 0, in_x_im = 0, in_y_re = 0, in_y_im = 0;
  logic        out_valid;
  logic [31:0] out_r_re, out_r_im;
  logic [1:0]  out_status;

  alu_scoreboard sb = new();
  int cycles = 0;

  complex_arith_unit_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_x_re(in_x_re), .in_x_im(in_x_im),
    .in_y_re(in_y_re), .in_y_im(in_y_im),
    .out_valid(out_valid), .out_r_re(out_r_re), .out_r_im(out_r_im),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid === 1'b1) sb.check_result(out_r_re, out_r_im, out_status);
    if (cycles > CYCLE_LIMIT) begin
      $display("complex_arith_unit_top test failed");
      $finish;
    end
  end

  task automatic send(logic [2:0] f, logic [31:0] xr, logic [31:0] xi,
                      logic [31:0] yr, logic [31:0] yi);
    start   <= 1'b1;
    in_func <= f;
    in_x_re <= xr;
    in_x_im <= xi;
    in_y_re <= yr;
    in_y_im <= yi;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(f, xr, xi, yr, yi);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      3: return $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 2) - 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] f;
    int sent, burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(FN_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FN_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
    send(FN_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FN_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
    send(FN_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
    send(FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(FN_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_8000);
    send(FN_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
    send(FN_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
    send(FN_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_1000, 32'h0100_0000);
    send(FN_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send(FN_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send(FN_ABS, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FN_ABS, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send(FN_ABS, 32'h0003_0000, 32'hFFFC_0000, 32'd0, 32'd0);
    send(FN_SQRT, 32'd0, 32'd0, 32'd0, 32'd0);
    send(FN_SQRT, 32'h0004_0000, 32'd0, 32'd0, 32'd0);
    send(FN_SQRT, 32'hFFFC_0000, 32'h0000_0000, 32'd0, 32'd0);
    send(FN_SQRT, 32'hFFFC_0000, 32'hFFFF_0000, 32'd0, 32'd0);
    send(FN_SQRT, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send(FN_SQRT, 32'h0000_0001, 32'h8000_0000, 32'd0, 32'd0);
    send(FN_BAD6, 32'h1234_5678, 32'h8765_4321, 32'h1, 32'h2);
    send(FN_BAD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        send(f, pick_operand(), pick_operand(), pick_operand(), pick_operand());
        sent++;
      end
      pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("complex_arith_unit_top test passed");
    end else begin
      $display("complex_arith_unit_top test failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/cau_pkg.sv
src/cau_sqrt_cell.sv
src/cau_div_cell.sv
src/cau_front.sv
src/cau_back.sv
src/complex_arith_unit_top.sv
tb/complex_arith_unit_top_tb.sv
